FILE: design/swat_pkg.sv
`default_nettype none

package swat_pkg;

  localparam int CMD_W      = 2;
  localparam int CLIENT_W   = 16;
  localparam int CHANNEL_W  = 8;
  localparam int HINT_W     = 8;
  localparam int SLOT_IDX_W = 4;
  localparam int STATUS_W   = 3;
  localparam int DEMAND_W   = 8;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [DEMAND_W-1:0] DEMAND_MAX  = 8'hFF;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSTALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_UP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DOWN      = 3'd1,
    ST_NOSLOT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOINSTALL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_NOTREADY = 2'd0,
    MODE_FREE     = 2'd1,
    MODE_BUSY     = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic                 has_client;
    logic [CLIENT_W-1:0]  client;
    logic [CHANNEL_W-1:0] channel;
  } slot_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_needed;
    logic walk_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/swat_if.sv
`default_nettype none

interface swat_req_if;
  logic                           valid;
  logic                           ready;
  logic [swat_pkg::CMD_W-1:0]     command;
  logic [swat_pkg::CLIENT_W-1:0]  client_id;
  logic [swat_pkg::CHANNEL_W-1:0] channel_id;
  logic [swat_pkg::HINT_W-1:0]    slot_hint;

  modport source (output valid, command, client_id, channel_id, slot_hint, input ready);
  modport sink (input valid, command, client_id, channel_id, slot_hint, output ready);
endinterface

interface swat_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [swat_pkg::STATUS_W-1:0]   status;
  logic [swat_pkg::SLOT_IDX_W-1:0] slot_index;
  logic                            newly_bound;
  logic [swat_pkg::DEMAND_W-1:0]   demand_count;
  logic                            exhausted;

  modport source (output valid, status, slot_index, newly_bound, demand_count, exhausted,
                  input ready);
  modport sink (input valid, status, slot_index, newly_bound, demand_count, exhausted,
                output ready);
endinterface

`default_nettype wire

FILE: design/session_worker_assign_table_unit.sv
// Worker slot assignment table with create, install and allocate requests.
// Create requests, allocates while the system is down and requests on an empty table skip
// the slot search; allocate and install otherwise read one slot per cycle and stop at a match.
// The next request is taken only once the result has registered; a result not taken holds
// the unit. Reset (rst, synchronous) clears slot count, demand and exhausted mark, turns the
// system off and sets the slot limit to 16; slot contents stay.
`default_nettype none

module session_worker_assign_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  swat_req_if.sink                              req,
  swat_rsp_if.source                            rsp,
  input  wire logic                             cfg_write,
  input  wire logic [swat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [swat_pkg::CFG_DATA_W-1:0]  cfg_data
);

  swat_pkg::ctrl_cmd_t cmd;
  swat_pkg::dp_stat_t  stat;

  swat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (req.command),
    .client_id    (req.client_id),
    .channel_id   (req.channel_id),
    .slot_hint    (req.slot_hint),
    .cmd          (cmd),
    .stat         (stat),
    .status       (rsp.status),
    .slot_index   (rsp.slot_index),
    .newly_bound  (rsp.newly_bound),
    .demand_count (rsp.demand_count),
    .exhausted    (rsp.exhausted)
  );

endmodule

`default_nettype wire

FILE: design/swat_ctrl.sv
`default_nettype none

module swat_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire swat_pkg::dp_stat_t  stat,
  output swat_pkg::ctrl_cmd_t      cmd
);

  swat_pkg::ctrl_state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swat_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.walk_needed ? swat_pkg::S_WALK : swat_pkg::S_FINISH;
        end
      end
      swat_pkg::S_WALK: begin
        if (stat.walk_last) begin
          state_next = swat_pkg::S_FINISH;
        end
      end
      swat_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = swat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swat_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == swat_pkg::S_IDLE);
    cmd.load   = (state == swat_pkg::S_IDLE) && in_valid;
    cmd.walk   = (state == swat_pkg::S_WALK);
    cmd.finish = (state == swat_pkg::S_FINISH) && out_free;
  end

  // Hold the result until taken; a finishing request refills the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && state == swat_pkg::S_IDLE)
    else $error("finished request did not produce a result");
`endif

endmodule

`default_nettype wire

FILE: design/swat_dp.sv
`default_nettype none

module swat_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [swat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [swat_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [swat_pkg::CMD_W-1:0]          command,
  input  wire logic [swat_pkg::CLIENT_W-1:0]       client_id,
  input  wire logic [swat_pkg::CHANNEL_W-1:0]      channel_id,
  input  wire logic [swat_pkg::HINT_W-1:0]         slot_hint,
  input  wire swat_pkg::ctrl_cmd_t                 cmd,
  output swat_pkg::dp_stat_t                       stat,
  output logic [swat_pkg::STATUS_W-1:0]            status,
  output logic [swat_pkg::SLOT_IDX_W-1:0]          slot_index,
  output logic                                     newly_bound,
  output logic [swat_pkg::DEMAND_W-1:0]            demand_count,
  output logic                                     exhausted
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int HCMP_W = (CNT_W > swat_pkg::HINT_W) ? CNT_W : swat_pkg::HINT_W;
  localparam int LCMP_W = (CNT_W > swat_pkg::LIMIT_W) ? CNT_W : swat_pkg::LIMIT_W;

  logic                               system_up;
  logic [swat_pkg::LIMIT_W-1:0]       slot_limit;
  logic [CNT_W-1:0]                   slot_count, slot_count_next;
  logic [swat_pkg::DEMAND_W-1:0]      demand, demand_next;
  logic                               limit_hit, limit_hit_next;

  logic [swat_pkg::CMD_W-1:0]         op;
  logic [swat_pkg::CLIENT_W-1:0]      op_client;
  logic [swat_pkg::CHANNEL_W-1:0]     op_channel;

  logic [IDX_W-1:0]                   iptr, iptr_inc, start_idx;
  logic [CNT_W-1:0]                   icnt, ccnt;
  logic                               chk_valid;
  logic [IDX_W-1:0]                   chk_idx;
  swat_pkg::slot_entry_t              rd_data;

  logic                               hit, have_free;
  logic [IDX_W-1:0]                   hit_idx, free_idx;
  swat_pkg::slot_entry_t              hit_word;

  swat_pkg::slot_entry_t              mem [TABLE_DEPTH];
  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  swat_pkg::slot_entry_t              mem_wdata;

  logic                               is_alloc, entry_match, chk_hit, checking, full;
  swat_pkg::status_t                  res_status;
  logic [IDX_W-1:0]                   res_idx;
  logic                               res_newly;

  always_ff @(posedge clk) begin
    if (rst) begin
      system_up  <= 1'b0;
      slot_limit <= swat_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        swat_pkg::CFG_SYSTEM_UP:  system_up  <= cfg_data[0];
        swat_pkg::CFG_SLOT_LIMIT: slot_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range hint starts the search at slot 0.
  assign start_idx = (HCMP_W'(slot_hint) < HCMP_W'(slot_count)) ? IDX_W'(slot_hint) : '0;
  assign iptr_inc  = (CNT_W'(iptr) + CNT_W'(1) == slot_count) ? '0 : iptr + IDX_W'(1);

  assign stat.walk_needed = (slot_count != '0) &&
                            (((command == swat_pkg::CMD_ALLOC) && system_up) ||
                             (command == swat_pkg::CMD_INSTALL));

  assign is_alloc    = (op == swat_pkg::CMD_ALLOC);
  assign entry_match = rd_data.has_client && (rd_data.client == op_client) &&
                       (rd_data.channel == op_channel);
  assign chk_hit     = is_alloc ? entry_match : (rd_data.mode == swat_pkg::MODE_NOTREADY);
  assign checking    = cmd.walk && chk_valid;
  assign stat.walk_last = checking && (chk_hit || ccnt == CNT_W'(1));

  assign full = (LCMP_W'(slot_count) >= LCMP_W'(slot_limit)) ||
                (slot_count == CNT_W'(TABLE_DEPTH));

  // Read pipeline: one slot issued per cycle, checked the cycle after.
  always_ff @(posedge clk) begin
    rd_data <= mem[iptr];
    chk_idx <= iptr;
    if (cmd.load) begin
      op         <= command;
      op_client  <= client_id;
      op_channel <= channel_id;
      iptr       <= (command == swat_pkg::CMD_ALLOC) ? start_idx : '0;
      icnt       <= slot_count;
      ccnt       <= slot_count;
      hit        <= 1'b0;
      have_free  <= 1'b0;
    end else if (cmd.walk) begin
      if (icnt != '0) begin
        iptr <= iptr_inc;
        icnt <= icnt - CNT_W'(1);
      end
      if (checking) begin
        ccnt <= ccnt - CNT_W'(1);
        if (chk_hit) begin
          hit      <= 1'b1;
          hit_idx  <= chk_idx;
          hit_word <= rd_data;
        end else if (is_alloc && !have_free && rd_data.mode == swat_pkg::MODE_FREE) begin
          have_free <= 1'b1;
          free_idx  <= chk_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.walk && (icnt != '0);
    end
  end

  always_comb begin
    res_status      = swat_pkg::ST_OK;
    res_idx         = '0;
    res_newly       = 1'b0;
    slot_count_next = slot_count;
    demand_next     = demand;
    limit_hit_next  = limit_hit;
    mem_we          = 1'b0;
    mem_waddr       = hit_idx;
    mem_wdata       = hit_word;
    case (op)
      swat_pkg::CMD_ALLOC: begin
        if (!system_up) begin
          res_status = swat_pkg::ST_DOWN;
        end else if (hit) begin
          res_idx = hit_idx;
          mem_we  = cmd.finish;
          if (hit_word.mode == swat_pkg::MODE_FREE) begin
            mem_wdata.mode = swat_pkg::MODE_BUSY;
          end
        end else if (have_free) begin
          res_idx              = free_idx;
          res_newly            = 1'b1;
          mem_we               = cmd.finish;
          mem_waddr            = free_idx;
          mem_wdata.mode       = swat_pkg::MODE_BUSY;
          mem_wdata.has_client = 1'b1;
          mem_wdata.client     = op_client;
          mem_wdata.channel    = op_channel;
        end else begin
          res_status = swat_pkg::ST_NOSLOT;
          if (!limit_hit && demand != swat_pkg::DEMAND_MAX) begin
            demand_next = demand + swat_pkg::DEMAND_W'(1);
          end
        end
      end
      swat_pkg::CMD_CREATE: begin
        demand_next = '0;
        if (full) begin
          res_status     = swat_pkg::ST_FULL;
          limit_hit_next = 1'b1;
        end else begin
          res_idx              = IDX_W'(slot_count);
          limit_hit_next       = 1'b0;
          slot_count_next      = slot_count + CNT_W'(1);
          mem_we               = cmd.finish;
          mem_waddr            = IDX_W'(slot_count);
          mem_wdata.mode       = swat_pkg::MODE_NOTREADY;
          mem_wdata.has_client = 1'b0;
          mem_wdata.client     = '0;
          mem_wdata.channel    = '0;
        end
      end
      swat_pkg::CMD_INSTALL: begin
        if (hit) begin
          res_idx        = hit_idx;
          mem_we         = cmd.finish;
          mem_wdata.mode = swat_pkg::MODE_FREE;
        end else begin
          res_status = swat_pkg::ST_NOINSTALL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      demand     <= '0;
      limit_hit  <= 1'b0;
    end else if (cmd.finish) begin
      slot_count <= slot_count_next;
      demand     <= demand_next;
      limit_hit  <= limit_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= res_status;
      slot_index   <= swat_pkg::SLOT_IDX_W'(res_idx);
      newly_bound  <= res_newly;
      demand_count <= demand_next;
      exhausted    <= limit_hit_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(TABLE_DEPTH))
    else $error("slot count beyond table depth");

  a_ptr_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> CNT_W'(iptr) < slot_count)
    else $error("search pointer outside populated slots");

  a_check_budget: assert property (@(posedge clk) disable iff (rst)
    checking |-> ccnt != '0 && ccnt >= icnt)
    else $error("slot checked beyond search length");
`endif

endmodule

`default_nettype wire
